FILE: src/wtr_pkg.sv
// Shared types, widths and constants for the wavelength-to-RGB pipeline.
// Used by wtr_decode, wtr_channel and wavelength_to_rgb_unit; depends on nothing.
package wtr_pkg;

   localparam int WL_W     = 14;
   localparam int OUT_W    = 16;
   localparam int RN_W     = 15;
   localparam int FN_W     = 14;
   localparam int W7_W     = WL_W + 3;
   localparam int P_W      = 23;
   localparam int A_W      = 30;
   localparam int B_W      = 26;
   localparam int RC_W     = 32;
   localparam int RC_SHIFT = 24;
   localparam int Q_W      = OUT_W + 1;
   localparam int X_W      = 43;
   localparam int Y_W      = B_W + 1 + Q_W;
   localparam int STAGES   = 5;

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;
   localparam int CH_NUM   = 3;

   localparam logic [WL_W-1:0] WL_380 = 14'd6080;
   localparam logic [WL_W-1:0] WL_420 = 14'd6720;
   localparam logic [WL_W-1:0] WL_440 = 14'd7040;
   localparam logic [WL_W-1:0] WL_490 = 14'd7840;
   localparam logic [WL_W-1:0] WL_510 = 14'd8160;
   localparam logic [WL_W-1:0] WL_580 = 14'd9280;
   localparam logic [WL_W-1:0] WL_645 = 14'd10320;
   localparam logic [WL_W-1:0] WL_700 = 14'd11200;
   localparam logic [WL_W-1:0] WL_780 = 14'd12480;

   // fade numerators: 7*w - 40640 on the rising edge, 91200 - 7*w on the falling edge
   localparam logic [W7_W-1:0] FN_RISE_OFS  = 17'd40640;
   localparam logic [W7_W-1:0] FN_FALL_BASE = 17'd91200;

   localparam logic [RN_W-1:0] RN_ONE  = 15'd16384;
   localparam logic [RN_W-1:0] RN_UNIT = 15'd1;

   // channel value = round(rn * fn * a / b); rc = floor(a * 2^RC_SHIFT / b)
   typedef struct packed {
      logic [A_W-1:0]  a;
      logic [B_W-1:0]  b;
      logic [RC_W-1:0] rc;
   } coef_type;

   typedef struct packed {
      logic                        in_band;
      logic [FN_W-1:0]             fn;
      logic [CH_NUM-1:0][RN_W-1:0] rn;
      coef_type [CH_NUM-1:0]       coef;
   } dec_type;

   localparam coef_type COEF_ZERO = '{A_W'(0), B_W'(1), RC_W'(0)};

   localparam coef_type COEF_RED_A = '{A_W'(80000), B_W'(16958187),
      RC_W'((64'd80000 << RC_SHIFT) / 64'd16958187)};
   localparam coef_type COEF_RED_B = '{A_W'(512000000), B_W'(16958187),
      RC_W'((64'd512000000 << RC_SHIFT) / 64'd16958187)};
   localparam coef_type COEF_RED_E = '{A_W'(1024000000), B_W'(39569103),
      RC_W'((64'd1024000000 << RC_SHIFT) / 64'd39569103)};
   localparam coef_type COEF_RED_FULL = '{A_W'(10000000), B_W'(5652729),
      RC_W'((64'd10000000 << RC_SHIFT) / 64'd5652729)};
   localparam coef_type COEF_RED_H = '{A_W'(12800000), B_W'(5652729),
      RC_W'((64'd12800000 << RC_SHIFT) / 64'd5652729)};

   localparam coef_type COEF_GRN_C = '{A_W'(16384), B_W'(295),
      RC_W'((64'd16384 << RC_SHIFT) / 64'd295)};
   localparam coef_type COEF_GRN_FULL = '{A_W'(160), B_W'(59),
      RC_W'((64'd160 << RC_SHIFT) / 64'd59)};
   localparam coef_type COEF_GRN_F = '{A_W'(32768), B_W'(767),
      RC_W'((64'd32768 << RC_SHIFT) / 64'd767)};

   localparam coef_type COEF_BLU_A = '{A_W'(20480), B_W'(2123),
      RC_W'((64'd20480 << RC_SHIFT) / 64'd2123)};
   localparam coef_type COEF_BLU_FULL = '{A_W'(8000), B_W'(2123),
      RC_W'((64'd8000 << RC_SHIFT) / 64'd2123)};
   localparam coef_type COEF_BLU_D = '{A_W'(409600), B_W'(2123),
      RC_W'((64'd409600 << RC_SHIFT) / 64'd2123)};

endpackage

FILE: src/wtr_decode.sv
// First pipeline stage: segment decode, ramp and fade numerators, per-channel coefficients.
// Depends on wtr_pkg.
module wtr_decode (
   input  logic                      clock,
   input  logic [wtr_pkg::WL_W-1:0]  wavelength,
   output wtr_pkg::dec_type          dec
);
   import wtr_pkg::*;

   logic [W7_W-1:0] w7;
   dec_type         dec_in;
   dec_type         dec_ff;

   always_comb begin
      w7 = {wavelength, 3'b000} - {3'b000, wavelength};
      dec_in.in_band = (wavelength >= WL_380) && (wavelength < WL_780);
      dec_in.fn = FN_W'(1);
      if (wavelength < WL_420) begin
         dec_in.fn = FN_W'(w7 - FN_RISE_OFS);
      end else if (wavelength >= WL_700) begin
         dec_in.fn = FN_W'(FN_FALL_BASE - w7);
      end
      dec_in.rn = '0;
      dec_in.coef = {COEF_ZERO, COEF_ZERO, COEF_ZERO};
      priority if ((wavelength < WL_380) || (wavelength >= WL_780)) begin
         dec_in.rn = '0;
      end else if (wavelength < WL_440) begin
         dec_in.rn[CH_RED] = RN_W'(WL_440 - wavelength);
         dec_in.coef[CH_RED] = (wavelength < WL_420) ? COEF_RED_A : COEF_RED_B;
         dec_in.rn[CH_BLUE] = (wavelength < WL_420) ? RN_UNIT : RN_ONE;
         dec_in.coef[CH_BLUE] = (wavelength < WL_420) ? COEF_BLU_A : COEF_BLU_FULL;
      end else if (wavelength < WL_490) begin
         dec_in.rn[CH_GREEN] = RN_W'(wavelength - WL_440);
         dec_in.coef[CH_GREEN] = COEF_GRN_C;
         dec_in.rn[CH_BLUE] = RN_ONE;
         dec_in.coef[CH_BLUE] = COEF_BLU_FULL;
      end else if (wavelength < WL_510) begin
         dec_in.rn[CH_GREEN] = RN_ONE;
         dec_in.coef[CH_GREEN] = COEF_GRN_FULL;
         dec_in.rn[CH_BLUE] = RN_W'(WL_510 - wavelength);
         dec_in.coef[CH_BLUE] = COEF_BLU_D;
      end else if (wavelength < WL_580) begin
         dec_in.rn[CH_RED] = RN_W'(wavelength - WL_510);
         dec_in.coef[CH_RED] = COEF_RED_E;
         dec_in.rn[CH_GREEN] = RN_ONE;
         dec_in.coef[CH_GREEN] = COEF_GRN_FULL;
      end else if (wavelength < WL_645) begin
         dec_in.rn[CH_RED] = RN_ONE;
         dec_in.coef[CH_RED] = COEF_RED_FULL;
         dec_in.rn[CH_GREEN] = RN_W'(WL_645 - wavelength);
         dec_in.coef[CH_GREEN] = COEF_GRN_F;
      end else begin
         dec_in.rn[CH_RED] = (wavelength < WL_700) ? RN_ONE : RN_UNIT;
         dec_in.coef[CH_RED] = (wavelength < WL_700) ? COEF_RED_FULL : COEF_RED_H;
      end
   end

   always_ff @(posedge clock) begin
      dec_ff <= dec_in;
   end

   assign dec = dec_ff;

endmodule

FILE: src/wtr_channel.sv
// Four-stage scaling datapath for one color channel: product, reciprocal estimate,
// exact remainder check, round and saturate. Depends on wtr_pkg.
module wtr_channel (
   input  logic                      clock,
   input  logic [wtr_pkg::RN_W-1:0]  rn,
   input  logic [wtr_pkg::FN_W-1:0]  fn,
   input  wtr_pkg::coef_type         coef,
   output logic [wtr_pkg::OUT_W-1:0] level
);
   import wtr_pkg::*;

   logic [RN_W+FN_W-1:0] rn_fn;
   logic [P_W+RC_W-1:0]  est;
   logic [A_W+P_W-1:0]   ap;
   logic [Q_W-1:0]       q_up;
   logic [Q_W-1:0]       q_fix;

   logic [P_W-1:0]  p_in,    p_ff;
   coef_type        coef_in, coef_ff;
   logic [X_W-1:0]  x_in,    x_ff;
   logic [Q_W-1:0]  q0_in,   q0_ff;
   logic [B_W-1:0]  b3_in,   b3_ff;
   logic [Y_W-1:0]  y_in,    y_ff;
   logic [Y_W-1:0]  m2_in,   m2_ff;
   logic [Q_W-1:0]  q4_in,   q4_ff;
   logic [OUT_W-1:0] lvl_in, lvl_ff;

   always_comb begin
      rn_fn   = (RN_W+FN_W)'(rn) * (RN_W+FN_W)'(fn);
      p_in    = rn_fn[P_W-1:0];
      coef_in = coef;

      est   = (P_W+RC_W)'(p_ff) * (P_W+RC_W)'(coef_ff.rc);
      ap    = (A_W+P_W)'(coef_ff.a) * (A_W+P_W)'(p_ff);
      x_in  = ap[X_W-1:0];
      q0_in = est[RC_SHIFT+Q_W-1:RC_SHIFT] + Q_W'(est[RC_SHIFT-1]);
      b3_in = coef_ff.b;

      q_up  = q0_ff + Q_W'(1);
      y_in  = {x_ff, 1'b0} + Y_W'(b3_ff);
      m2_in = Y_W'({b3_ff, 1'b0}) * Y_W'(q_up);
      q4_in = q0_ff;

      q_fix  = q4_ff + Q_W'(y_ff >= m2_ff);
      lvl_in = q_fix[Q_W-1] ? {OUT_W{1'b1}} : q_fix[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      coef_ff <= coef_in;
      x_ff    <= x_in;
      q0_ff   <= q0_in;
      b3_ff   <= b3_in;
      y_ff    <= y_in;
      m2_ff   <= m2_in;
      q4_ff   <= q4_in;
      lvl_ff  <= lvl_in;
   end

   assign level = lvl_ff;

endmodule

FILE: src/wavelength_to_rgb_unit.sv
// Wavelength to RGB color map: decode stage plus one scaling datapath per channel.
// The valid and in_band pipes line up with the decode and channel registers.
// Throughput: one wavelength per cycle; busy is low except while reset is high.
// Reset clears the valid pipeline only; the receiver cannot stall the result beat.
// Depends on wtr_pkg, wtr_decode and wtr_channel.
module wavelength_to_rgb_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [wtr_pkg::WL_W-1:0]  req_wavelength,
   output logic                      rsp_valid,
   output logic [wtr_pkg::OUT_W-1:0] rsp_red,
   output logic [wtr_pkg::OUT_W-1:0] rsp_green,
   output logic [wtr_pkg::OUT_W-1:0] rsp_blue,
   output logic                      rsp_in_band
);
   import wtr_pkg::*;

   dec_type           dec;
   logic              accept;
   logic [STAGES-1:0] valid_in,   valid_ff;
   logic [STAGES-2:0] band_in,    band_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   wtr_decode u_decode (
      .clock      (clock),
      .wavelength (req_wavelength),
      .dec        (dec)
   );

   wtr_channel u_red (
      .clock (clock),
      .rn    (dec.rn[CH_RED]),
      .fn    (dec.fn),
      .coef  (dec.coef[CH_RED]),
      .level (rsp_red)
   );

   wtr_channel u_green (
      .clock (clock),
      .rn    (dec.rn[CH_GREEN]),
      .fn    (dec.fn),
      .coef  (dec.coef[CH_GREEN]),
      .level (rsp_green)
   );

   wtr_channel u_blue (
      .clock (clock),
      .rn    (dec.rn[CH_BLUE]),
      .fn    (dec.fn),
      .coef  (dec.coef[CH_BLUE]),
      .level (rsp_blue)
   );

   always_comb begin
      valid_in = {valid_ff[STAGES-2:0], accept};
      band_in  = {band_ff[STAGES-3:0], dec.in_band};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      band_ff <= band_in;
   end

   assign rsp_valid   = valid_ff[STAGES-1];
   assign rsp_in_band = band_ff[STAGES-2];

endmodule

FILE: tb/tb_wavelength_to_rgb_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for wavelength_to_rgb_unit: drives wavelength beats with random gaps,
// predicts each RGB beat in exact rational arithmetic and compares every field in order.
// Depends on wtr_pkg and the wavelength_to_rgb_unit RTL.
module tb_wavelength_to_rgb_unit;
   import wtr_pkg::*;

   localparam int RANDOM_ITEMS   = 1250;
   localparam int MAX_GAP        = 18;
   localparam int IDLE_LIMIT     = 400;
   localparam int TAIL_CYCLES    = 20;
   localparam int DRAIN_INTERVAL = 250;

   localparam longint unsigned RED_GAIN_NUM = 64'd10000000;
   localparam longint unsigned RED_GAIN_DEN = 64'd5652729;
   localparam longint unsigned GRN_GAIN_NUM = 64'd160;
   localparam longint unsigned GRN_GAIN_DEN = 64'd59;
   localparam longint unsigned BLU_GAIN_NUM = 64'd8000;
   localparam longint unsigned BLU_GAIN_DEN = 64'd2123;

   typedef struct {
      logic [WL_W-1:0] wl;
      int unsigned     gap;
      bit              drain;
   } wl_item_t;

   typedef struct {
      logic [WL_W-1:0]  wl;
      logic [OUT_W-1:0] red;
      logic [OUT_W-1:0] green;
      logic [OUT_W-1:0] blue;
      logic             in_band;
   } color_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic [WL_W-1:0]      req_wavelength = '0;
   logic                 busy;
   logic                 rsp_valid;
   logic [OUT_W-1:0]     rsp_red;
   logic [OUT_W-1:0]     rsp_green;
   logic [OUT_W-1:0]     rsp_blue;
   logic                 rsp_in_band;

   wl_item_t wl_pending_q[$];
   color_t   color_expect_q[$];

   int  gap_left      = 0;
   bit  gap_loaded    = 1'b0;
   int  idle_cycles   = 0;
   int  beats_sent    = 0;
   int  beats_checked = 0;
   int  in_band_beats = 0;
   int  drain_pauses  = 0;
   int  mismatch_count = 0;

   wavelength_to_rgb_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_wavelength (req_wavelength),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_in_band    (rsp_in_band)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // round(ramp * fade * gain * 2^14), ties upward, saturated
   function automatic logic [OUT_W-1:0] scale_ramp(longint unsigned rn, longint unsigned rd,
                                                   longint unsigned fn, longint unsigned fd,
                                                   longint unsigned gn, longint unsigned gd);
      longint unsigned n;
      longint unsigned d;
      longint unsigned q;
      n = 64'd16384 * rn * fn * gn;
      d = rd * fd * gd;
      q = (64'd2 * n + d) / (64'd2 * d);
      return (q > 64'd65535) ? 16'hFFFF : q[OUT_W-1:0];
   endfunction

   function automatic color_t predict_color(logic [WL_W-1:0] wl);
      color_t          c;
      longint unsigned w;
      longint unsigned fn;
      longint unsigned fd;
      longint unsigned rn [CH_NUM];
      longint unsigned rd [CH_NUM];
      c.wl      = wl;
      c.red     = '0;
      c.green   = '0;
      c.blue    = '0;
      c.in_band = 1'b0;
      w = wl;
      if (w < WL_380 || w >= WL_780)
         return c;
      rn[CH_RED] = 0;   rd[CH_RED] = 1;
      rn[CH_GREEN] = 0; rd[CH_GREEN] = 1;
      rn[CH_BLUE] = 0;  rd[CH_BLUE] = 1;
      if (w < WL_440) begin
         rn[CH_RED] = WL_440 - w;  rd[CH_RED] = WL_440 - WL_380;
         rn[CH_BLUE] = 1;
      end else if (w < WL_490) begin
         rn[CH_GREEN] = w - WL_440; rd[CH_GREEN] = WL_490 - WL_440;
         rn[CH_BLUE] = 1;
      end else if (w < WL_510) begin
         rn[CH_GREEN] = 1;
         rn[CH_BLUE] = WL_510 - w;  rd[CH_BLUE] = WL_510 - WL_490;
      end else if (w < WL_580) begin
         rn[CH_RED] = w - WL_510;   rd[CH_RED] = WL_580 - WL_510;
         rn[CH_GREEN] = 1;
      end else if (w < WL_645) begin
         rn[CH_RED] = 1;
         rn[CH_GREEN] = WL_645 - w; rd[CH_GREEN] = WL_645 - WL_580;
      end else begin
         rn[CH_RED] = 1;
      end
      // fade = 0.3 + 0.7 * t as (3*span + 7*dist) / (10*span)
      if (w < WL_420) begin
         fn = 3 * (WL_420 - WL_380) + 7 * (w - WL_380);
         fd = 10 * (WL_420 - WL_380);
      end else if (w < WL_700) begin
         fn = 1;
         fd = 1;
      end else begin
         fn = 3 * (WL_780 - WL_700) + 7 * (WL_780 - w);
         fd = 10 * (WL_780 - WL_700);
      end
      c.red     = scale_ramp(rn[CH_RED], rd[CH_RED], fn, fd, RED_GAIN_NUM, RED_GAIN_DEN);
      c.green   = scale_ramp(rn[CH_GREEN], rd[CH_GREEN], fn, fd, GRN_GAIN_NUM, GRN_GAIN_DEN);
      c.blue    = scale_ramp(rn[CH_BLUE], rd[CH_BLUE], fn, fd, BLU_GAIN_NUM, BLU_GAIN_DEN);
      c.in_band = 1'b1;
      return c;
   endfunction

   task automatic report_mismatch(string what, logic [WL_W-1:0] wl, int unsigned got,
                                  int unsigned want);
      $display("%0t: MISMATCH %s for wavelength %0d: got %0d, want %0d",
               $time, what, wl, got, want);
      mismatch_count++;
   endtask

   task automatic add_item(logic [WL_W-1:0] wl, int unsigned gap, bit drain);
      wl_item_t item;
      item.wl    = wl;
      item.gap   = gap;
      item.drain = drain;
      wl_pending_q.push_back(item);
   endtask

   // driver: present the head of the pending queue, hold it until accepted
   always @(posedge clock) begin
      if (reset) begin
         start      <= 1'b0;
         gap_loaded = 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            color_expect_q.push_back(predict_color(req_wavelength));
            void'(wl_pending_q.pop_front());
            beats_sent++;
            gap_loaded = 1'b0;
         end
         if (wl_pending_q.size() == 0) begin
            start <= 1'b0;
         end else begin
            if (!gap_loaded) begin
               gap_left   = wl_pending_q[0].gap;
               gap_loaded = 1'b1;
               if (wl_pending_q[0].drain)
                  drain_pauses++;
            end
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (wl_pending_q[0].drain &&
                         (color_expect_q.size() != 0 || rsp_valid)) begin
               start <= 1'b0;
            end else begin
               start          <= 1'b1;
               req_wavelength <= wl_pending_q[0].wl;
            end
         end
      end
   end

   // monitor: check each result beat against the oldest predicted color
   always @(posedge clock) begin
      color_t want;
      if (!reset && rsp_valid) begin
         if (color_expect_q.size() == 0) begin
            report_mismatch("unexpected beat", '0, rsp_valid, 0);
         end else begin
            want = color_expect_q.pop_front();
            if (rsp_red !== want.red)
               report_mismatch("red", want.wl, rsp_red, want.red);
            if (rsp_green !== want.green)
               report_mismatch("green", want.wl, rsp_green, want.green);
            if (rsp_blue !== want.blue)
               report_mismatch("blue", want.wl, rsp_blue, want.blue);
            if (rsp_in_band !== want.in_band)
               report_mismatch("in_band", want.wl, rsp_in_band, want.in_band);
            if (want.in_band)
               in_band_beats++;
         end
         beats_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout with %0d items pending and %0d results outstanding",
                  $time, wl_pending_q.size(), color_expect_q.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int  pick;
      int  base;
      int  wl_val;
      bit  burst;
      int unsigned gap;

      // directed: field extremes, band edges, segment boundaries and fade edges
      add_item(14'd0, 0, 1'b0);
      add_item(14'h3FFF, 0, 1'b0);
      add_item(WL_380 - 14'd1, 0, 1'b0);
      add_item(WL_380, 0, 1'b0);
      add_item(WL_380 + 14'd1, 0, 1'b0);
      add_item(WL_420 - 14'd1, 0, 1'b0);
      add_item(WL_420, 0, 1'b0);
      add_item(WL_440 - 14'd1, 0, 1'b0);
      add_item(WL_440, 0, 1'b0);
      add_item(WL_490 - 14'd1, 0, 1'b0);
      add_item(WL_490, 0, 1'b0);
      add_item(WL_510 - 14'd1, 3, 1'b0);
      add_item(WL_510, 0, 1'b0);
      add_item(WL_580 - 14'd1, 0, 1'b0);
      add_item(WL_580, 0, 1'b0);
      add_item(WL_645 - 14'd1, 0, 1'b1);
      add_item(WL_645, 0, 1'b0);
      add_item(WL_700 - 14'd1, 1, 1'b0);
      add_item(WL_700, 0, 1'b0);
      add_item(WL_780 - 14'd1, 0, 1'b0);
      add_item(WL_780, 0, 1'b0);
      add_item(14'd8000, 0, 1'b0);
      add_item(14'd12000, 0, 1'b0);
      add_item(14'h2AAA, 0, 1'b0);
      add_item(14'h1555, 0, 1'b0);

      burst = 1'b0;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 64 == 0)
            burst = ($urandom_range(0, 2) == 0);
         gap  = burst ? 0 : $urandom_range(0, MAX_GAP);
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            wl_val = $urandom_range(WL_380, WL_780 - 1);
         end else if (pick < 85) begin
            case ($urandom_range(0, 8))
               0: base = WL_380;
               1: base = WL_420;
               2: base = WL_440;
               3: base = WL_490;
               4: base = WL_510;
               5: base = WL_580;
               6: base = WL_645;
               7: base = WL_700;
               default: base = WL_780;
            endcase
            wl_val = base + $urandom_range(0, 6) - 3;
         end else begin
            wl_val = $urandom_range(0, 16383);
         end
         add_item(wl_val[WL_W-1:0], gap, (k % DRAIN_INTERVAL) == DRAIN_INTERVAL - 1);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (wl_pending_q.size() != 0 || color_expect_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d of %0d wavelength beats (%0d in band, %0d out of band),",
               beats_checked, beats_sent, in_band_beats, beats_checked - in_band_beats);
      $display("with %0d drain pauses and random gaps of 0 to %0d cycles; %0d mismatches.",
               drain_pauses, MAX_GAP, mismatch_count);
      if (mismatch_count == 0 && color_expect_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: files.f
src/wtr_pkg.sv
src/wtr_decode.sv
src/wtr_channel.sv
src/wavelength_to_rgb_unit.sv
tb/tb_wavelength_to_rgb_unit.sv
